FILE: design/grt_pkg.sv
// Shared types and constants for the gradient residual tokenizer.
`timescale 1ns / 1ps

package grt_pkg;

    // Fixed field widths of the token stream.
    localparam int unsigned CTX_W      = 16;
    localparam int unsigned RES_W      = 17;
    localparam int unsigned TIDX_W     = 10;
    localparam int unsigned OUT_DATA_W = 40;

    // Configuration port geometry.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Register widths.
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned RWIDTH_W = 11;
    localparam int unsigned RCOUNT_W = 16;

    // Register map, by word index.
    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_FIXED_CTX = 2'd1,
        REG_ROW_WIDTH = 2'd2,
        REG_ROW_COUNT = 2'd3
    } t_reg_idx;

    // Predictor modes; the unused code behaves as the gradient mode.
    localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TABLE = 2'd2;

    // Input transaction kinds carried on tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TABLE  = 1'b1;

    // Reset values of the registers.
    localparam logic [MODE_W-1:0]   RST_MODE      = MODE_GRAD;
    localparam logic [CTX_W-1:0]    RST_FIXED_CTX = 16'd0;
    localparam logic [RWIDTH_W-1:0] RST_ROW_WIDTH = 11'd1024;
    localparam logic [RCOUNT_W-1:0] RST_ROW_COUNT = 16'd1024;

endpackage

FILE: design/gradient_residual_tokenizer.sv
// Top level of the gradient residual tokenizer: predictor, line buffer and context table.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one transaction per sample of a channel in raster
// order (tuser low) or one context table write (tuser high). The master
// stream returns one token per sample: context id and zigzag residual in
// tdata, and tlast on the final sample of the channel. Table writes give no
// token. The APB port sets mode, fixed context, row width and row count;
// write it only while the block is idle. Writing row width or row count
// restarts the channel at its first sample.
// Throughput: one transaction per cycle while the receiver takes tokens,
// set by the two register stages: the line buffer read at acceptance, then
// the predictor and the context table read into the output register.
// Reset returns the registers to their defaults and the position to the
// first sample. The line buffer and the table hold no reset value.
// When the receiver stalls, the token holds in the output register and the
// block still takes one more transaction into its first stage if that is empty.
module gradient_residual_tokenizer #(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned PROP_RANGE  = 512,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, low bit up: sample_value, table_index, table_context, zero fill.
    input  logic [((SAMPLE_BITS+26+7)/8)*8-1:0] s_axis_tdata,
    // tuser: command.
    input  logic                                s_axis_tuser,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, low bit up: context_id, packed_residual, zero fill.
    output logic [grt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [grt_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [grt_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [grt_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import grt_pkg::*;

    localparam int unsigned SB  = SAMPLE_BITS;
    localparam int unsigned AW  = SAMPLE_BITS + 2;
    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned WW  = CW + 1;
    localparam int unsigned TD  = 2 * PROP_RANGE;
    localparam int unsigned TAW = $clog2(TD);
    localparam int unsigned PAD_W     = OUT_DATA_W - CTX_W - RES_W;

    // Configuration registers.
    logic [MODE_W-1:0]   r_mode;
    logic [CTX_W-1:0]    r_fixed_ctx;
    logic [RWIDTH_W-1:0] r_row_width;
    logic [RCOUNT_W-1:0] r_row_count;

    // Position of the next sample to be accepted.
    logic [CW-1:0]       r_col;
    logic [RCOUNT_W-1:0] r_row;

    // Neighbor samples left behind by the previous sample.
    logic signed [SB-1:0] r_left;
    logic signed [SB-1:0] r_al;

    // Memories: previous row and context table.
    logic signed [SB-1:0] r_above_mem [MAX_WIDTH];
    logic [CTX_W-1:0]     r_ctx_mem [TD];

    // Stage one: accepted transaction and its position.
    logic                 r1_valid;
    logic                 r1_cmd;
    logic signed [SB-1:0] r1_s;
    logic [TIDX_W-1:0]    r1_idx;
    logic [CTX_W-1:0]     r1_tctx;
    logic [CW-1:0]        r1_x;
    logic                 r1_xnz;
    logic                 r1_ynz;
    logic                 r1_last;
    logic signed [SB-1:0] r_up;

    // Stage two: output token.
    logic                 r2_valid;
    logic                 r2_use_tbl;
    logic [CTX_W-1:0]     r2_fixed;
    logic [RES_W-1:0]     r2_res;
    logic                 r2_last;
    logic [CTX_W-1:0]     r_tbl_q;

    // Handshake and position signals.
    logic                 w_cfg_wr;
    t_reg_idx             w_reg;
    logic                 w_en1;
    logic                 w_en2;
    logic                 w_acc;
    logic                 w_acc_smp;
    logic                 w_adv_smp;
    logic                 w_adv_tbl;
    logic [WW-1:0]        w_w;
    logic [RCOUNT_W-1:0]  w_h;
    logic [CW-1:0]        w_x;
    logic [RCOUNT_W-1:0]  w_y;
    logic                 w_last;
    logic                 w_wrap;
    logic [CW-1:0]        n_col;
    logic [RCOUNT_W-1:0]  n_row;

    // Predictor signals.
    logic signed [SB-1:0] w_up;
    logic signed [SB-1:0] w_lft;
    logic signed [SB-1:0] w_top;
    logic signed [SB-1:0] w_tl;
    logic signed [AW-1:0] w_grad;
    logic signed [SB-1:0] w_lo;
    logic signed [SB-1:0] w_hi;
    logic signed [SB-1:0] w_guess;
    logic signed [SB:0]   w_resid;
    logic [AW-1:0]        w_zz;
    logic [63:0]          w_zz64;
    logic signed [31:0]   w_g32;
    logic signed [31:0]   w_gsat;
    logic [TAW-1:0]       w_taddr;
    logic                 w_tidx_ok;

    // Input field views.
    logic signed [SB-1:0] w_in_s;
    logic [TIDX_W-1:0]    w_in_idx;
    logic [CTX_W-1:0]     w_in_tctx;

    assign w_in_s    = s_axis_tdata[SB-1:0];
    assign w_in_idx  = s_axis_tdata[SB+TIDX_W-1:SB];
    assign w_in_tctx = s_axis_tdata[SB+TIDX_W+CTX_W-1:SB+TIDX_W];

    // Pipeline enables: each stage moves when the one after it has room.
    assign w_en2     = !r2_valid || m_axis_tready;
    assign w_en1     = !r1_valid || w_en2;
    assign w_acc     = s_axis_tvalid && w_en1;
    assign w_acc_smp = w_acc && (s_axis_tuser == CMD_SAMPLE);
    assign w_adv_smp = w_en2 && r1_valid && (r1_cmd == CMD_SAMPLE);
    assign w_adv_tbl = w_en2 && r1_valid && (r1_cmd == CMD_TABLE) && w_tidx_ok;
    assign s_axis_tready = w_en1;

    // APB access; a write completes in the access cycle.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (w_reg)
            REG_MODE:      prdata = APB_DATA_W'(r_mode);
            REG_FIXED_CTX: prdata = APB_DATA_W'(r_fixed_ctx);
            REG_ROW_WIDTH: prdata = APB_DATA_W'(r_row_width);
            REG_ROW_COUNT: prdata = APB_DATA_W'(r_row_count);
            default:       prdata = '0;
        endcase
    end

    // Effective geometry: zero counts act as one, wide rows saturate.
    always_comb begin
        if (r_row_width == '0) begin
            w_w = WW'(1);
        end else if (32'(r_row_width) > 32'(MAX_WIDTH)) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_row_width);
        end
        w_h = (r_row_count == '0) ? RCOUNT_W'(1) : r_row_count;
    end

    // Position of the sample at the input and the position after it.
    always_comb begin
        w_x    = ({1'b0, r_col} >= w_w) ? '0 : r_col;
        w_y    = (r_row >= w_h) ? '0 : r_row;
        w_last = (w_y == w_h - RCOUNT_W'(1)) && ({1'b0, w_x} == w_w - WW'(1));
        w_wrap = ({1'b0, w_x} + WW'(1)) >= w_w;
        if (w_last) begin
            n_col = '0;
            n_row = '0;
        end else if (w_wrap) begin
            n_col = '0;
            n_row = w_y + RCOUNT_W'(1);
        end else begin
            n_col = w_x + CW'(1);
            n_row = w_y;
        end
    end

    // Configuration registers and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_MODE;
            r_fixed_ctx <= RST_FIXED_CTX;
            r_row_width <= RST_ROW_WIDTH;
            r_row_count <= RST_ROW_COUNT;
            r_col       <= '0;
            r_row       <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_MODE:      r_mode      <= pwdata[MODE_W-1:0];
                REG_FIXED_CTX: r_fixed_ctx <= pwdata[CTX_W-1:0];
                REG_ROW_WIDTH: begin
                    r_row_width <= pwdata[RWIDTH_W-1:0];
                    r_col       <= '0;
                    r_row       <= '0;
                end
                REG_ROW_COUNT: begin
                    r_row_count <= pwdata[RCOUNT_W-1:0];
                    r_col       <= '0;
                    r_row       <= '0;
                end
                default: r_mode <= r_mode;
            endcase
        end else if (w_acc_smp) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line buffer: written as a sample leaves stage one, read at acceptance.
    // A read of the column being written in the same cycle takes the new sample.
    always_ff @(posedge i_clk) begin
        if (w_adv_smp) begin
            r_above_mem[r1_x] <= r1_s;
        end
        if (w_acc_smp) begin
            if (w_adv_smp && (r1_x == w_x)) begin
                r_up <= r1_s;
            end else begin
                r_up <= r_above_mem[w_x];
            end
        end
    end

    // Stage one control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en1) begin
            r1_valid <= w_acc;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r1_cmd  <= s_axis_tuser;
            r1_s    <= w_in_s;
            r1_idx  <= w_in_idx;
            r1_tctx <= w_in_tctx;
            r1_x    <= w_x;
            r1_xnz  <= (w_x != '0);
            r1_ynz  <= (w_y != '0);
            r1_last <= w_last;
        end
    end

    // Neighbors with the edge rules of the first row and column.
    always_comb begin
        w_up  = r1_ynz ? r_up : '0;
        w_lft = r1_xnz ? r_left : w_up;
        w_top = r1_ynz ? w_up : w_lft;
        w_tl  = (r1_xnz && r1_ynz) ? r_al : w_lft;
    end

    // Clamped gradient prediction and zigzag residual; zero mode takes the sample as residual.
    always_comb begin
        w_grad = AW'(w_top) + AW'(w_lft) - AW'(w_tl);
        w_lo   = (w_top < w_lft) ? w_top : w_lft;
        w_hi   = (w_top < w_lft) ? w_lft : w_top;
        if (w_grad < AW'(w_lo)) begin
            w_guess = w_lo;
        end else if (w_grad > AW'(w_hi)) begin
            w_guess = w_hi;
        end else begin
            w_guess = SB'(w_grad);
        end
        if (r_mode == MODE_ZERO) begin
            w_resid = (SB+1)'(r1_s);
        end else begin
            w_resid = (SB+1)'(r1_s) - (SB+1)'(w_guess);
        end
        w_zz   = {w_resid, 1'b0} ^ {AW{w_resid[SB]}};
        w_zz64 = 64'(w_zz);
    end

    // Table address: gradient saturated to the property range, then offset.
    always_comb begin
        w_g32 = 32'(w_grad);
        if (w_g32 < -$signed(32'(PROP_RANGE))) begin
            w_gsat = -$signed(32'(PROP_RANGE));
        end else if (w_g32 > $signed(32'(PROP_RANGE - 1))) begin
            w_gsat = $signed(32'(PROP_RANGE - 1));
        end else begin
            w_gsat = w_g32;
        end
        w_taddr   = TAW'(w_gsat + $signed(32'(PROP_RANGE)));
        w_tidx_ok = 32'(r1_idx) < 32'(TD);
    end

    // Context table: loaded by table transactions, read for each sample.
    always_ff @(posedge i_clk) begin
        if (w_adv_tbl) begin
            r_ctx_mem[TAW'(r1_idx)] <= r1_tctx;
        end
        if (w_adv_smp) begin
            r_tbl_q <= r_ctx_mem[w_taddr];
        end
    end

    // Neighbor state; the channel end and a row width or row count write return it to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_al   <= '0;
        end else if (w_cfg_wr && (w_reg == REG_ROW_WIDTH || w_reg == REG_ROW_COUNT)) begin
            r_left <= '0;
            r_al   <= '0;
        end else if (w_adv_smp) begin
            if (r1_last) begin
                r_left <= '0;
                r_al   <= '0;
            end else begin
                r_left <= r1_s;
                r_al   <= w_up;
            end
        end
    end

    // Stage two control: only samples make a token.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en2) begin
            r2_valid <= r1_valid && (r1_cmd == CMD_SAMPLE);
        end
    end

    // Stage two payload.
    always_ff @(posedge i_clk) begin
        if (w_adv_smp) begin
            r2_use_tbl <= (r_mode == MODE_TABLE);
            r2_fixed   <= r_fixed_ctx;
            r2_res     <= w_zz64[RES_W-1:0];
            r2_last    <= r1_last;
        end
    end

    // Output stream.
    assign m_axis_tvalid = r2_valid;
    assign m_axis_tdata  = {PAD_W'(0), r2_res, (r2_use_tbl ? r_tbl_q : r2_fixed)};
    assign m_axis_tlast  = r2_last;

    // The position counter never leaves the line buffer.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(MAX_WIDTH))
        else $error("column counter beyond line buffer");

    // A table transaction leaving stage one makes no token.
    a_tbl_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en2 && r1_valid && (r1_cmd == CMD_TABLE)) |=> !r2_valid)
        else $error("table write produced a token");

    // The final sample of a channel clears the neighbor state.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv_smp && r1_last) |=> (r_left == '0 && r_al == '0))
        else $error("neighbor state not cleared at channel end");

    // Accepting the final sample of a channel restarts the position.
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_smp && w_last && !w_cfg_wr) |=> (r_col == '0 && r_row == '0))
        else $error("position not restarted after final sample");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the gradient residual tokenizer: stream stimulus, token prediction and checks.
`timescale 1ns / 1ps

module tb_top;
    import grt_pkg::*;

    localparam int unsigned MAX_W          = 1024;
    localparam int unsigned PROP           = 512;
    localparam int unsigned TAB_DEPTH      = 2 * PROP;
    localparam int unsigned IN_DATA_W      = ((16 + 26 + 7) / 8) * 8;
    localparam int unsigned RANDOM_SAMPLES = 400;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned MAX_REPORTS    = 20;

    // One token as the block should emit it.
    typedef struct packed {
        logic [CTX_W-1:0] ctx;
        logic [RES_W-1:0] res;
        logic             chan_end;
    } t_token;

    // One input transaction together with the token it should cause.
    typedef struct packed {
        logic              cmd;
        logic [15:0]       sample;
        logic [TIDX_W-1:0] tidx;
        logic [CTX_W-1:0]  tctx;
        t_token            tok;
    } t_stim_item;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata, low bit up: sample_value, table_index, table_context, zero fill.
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // tuser: command.
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata, low bit up: context_id, packed_residual, zero fill.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gradient_residual_tokenizer #(
        .MAX_WIDTH  (MAX_W),
        .PROP_RANGE (PROP),
        .SAMPLE_BITS(16)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    // Queues between generator, driver and monitor.
    t_stim_item  pending_q[$];
    t_token      token_q[$];
    t_stim_item  cur_item = '0;
    t_token      want_tok;
    bit          in_fire = 1'b0;

    int unsigned gen_count      = 0;
    int unsigned acc_count      = 0;
    int unsigned sample_count   = 0;
    int unsigned table_count    = 0;
    int unsigned tokens_checked = 0;
    int unsigned chan_ends      = 0;
    int unsigned cfg_writes     = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // Predictor state: line buffer, context table, neighbors, position.
    int               line_buf [MAX_W];
    logic [CTX_W-1:0] ctx_tab  [TAB_DEPTH];
    bit               tab_valid[TAB_DEPTH];
    int               left_q       = 0;
    int               above_left_q = 0;
    int unsigned      col_q        = 0;
    int unsigned      row_q        = 0;

    // Predictor copy of the registers.
    logic [MODE_W-1:0]   cfg_mode  = RST_MODE;
    logic [CTX_W-1:0]    cfg_ctx   = RST_FIXED_CTX;
    logic [RWIDTH_W-1:0] cfg_width = RST_ROW_WIDTH;
    logic [RCOUNT_W-1:0] cfg_rows  = RST_ROW_COUNT;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic int unsigned row_len();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned row_total();
        return (cfg_rows == 0) ? 1 : cfg_rows;
    endfunction

    function automatic void restart_channel();
        col_q        = 0;
        row_q        = 0;
        left_q       = 0;
        above_left_q = 0;
    endfunction

    // Neighbors of the current position with the edge rules; a position left
    // beyond a shrunk geometry folds back to the start first.
    function automatic void fetch_neighbors(output int up, output int lft,
                                            output int top, output int tl);
        if (col_q >= row_len()) col_q = 0;
        if (row_q >= row_total()) row_q = 0;
        up  = (row_q != 0) ? line_buf[col_q] : 0;
        lft = (col_q != 0) ? left_q : up;
        top = (row_q != 0) ? up : lft;
        tl  = (col_q != 0 && row_q != 0) ? above_left_q : lft;
    endfunction

    // Context table slot: the raw gradient saturated to the property range, then offset.
    function automatic int unsigned table_slot(input int grad);
        int sat;
        sat = grad;
        if (sat < -int'(PROP)) sat = -int'(PROP);
        if (sat > int'(PROP) - 1) sat = int'(PROP) - 1;
        return int'(PROP) + sat;
    endfunction

    // Token of one sample; advances the predictor position.
    function automatic t_token tokenize_sample(input logic [15:0] raw);
        int          up, lft, top, tl, grad, lo, hi, guess, s, r, z;
        int unsigned w, h;
        t_token      tok;
        fetch_neighbors(up, lft, top, tl);
        w     = row_len();
        h     = row_total();
        s     = $signed(raw);
        grad  = top + lft - tl;
        lo    = (top < lft) ? top : lft;
        hi    = (top < lft) ? lft : top;
        guess = (grad < lo) ? lo : ((grad > hi) ? hi : grad);
        case (cfg_mode)
            MODE_ZERO: begin
                r       = s;
                tok.ctx = cfg_ctx;
            end
            MODE_TABLE: begin
                r       = s - guess;
                tok.ctx = ctx_tab[table_slot(grad)];
            end
            default: begin
                r       = s - guess;
                tok.ctx = cfg_ctx;
            end
        endcase
        above_left_q    = up;
        line_buf[col_q] = s;
        left_q          = s;
        tok.chan_end    = (row_q == h - 1) && (col_q == w - 1);
        if (tok.chan_end) begin
            restart_channel();
        end else if (col_q + 1 >= w) begin
            col_q = 0;
            row_q = row_q + 1;
        end else begin
            col_q = col_q + 1;
        end
        z       = (r >= 0) ? 2 * r : -2 * r - 1;
        tok.res = z[RES_W-1:0];
        return tok;
    endfunction

    function automatic void queue_table(input logic [TIDX_W-1:0] idx, input logic [CTX_W-1:0] ctx);
        t_stim_item it;
        it.cmd         = CMD_TABLE;
        it.sample      = 16'($urandom);
        it.tidx        = idx;
        it.tctx        = ctx;
        it.tok         = '0;
        ctx_tab[idx]   = ctx;
        tab_valid[idx] = 1'b1;
        pending_q      = {pending_q, it};
        gen_count++;
        table_count++;
    endfunction

    // In table mode a slot that was never loaded gets an entry just before
    // the sample that reads it.
    function automatic void queue_sample(input logic [15:0] raw);
        t_stim_item  it;
        int          up, lft, top, tl;
        int unsigned slot;
        if (cfg_mode == MODE_TABLE) begin
            fetch_neighbors(up, lft, top, tl);
            slot = table_slot(top + lft - tl);
            if (!tab_valid[slot]) queue_table(TIDX_W'(slot), CTX_W'($urandom));
        end
        it.cmd    = CMD_SAMPLE;
        it.sample = raw;
        it.tidx   = TIDX_W'($urandom);
        it.tctx   = CTX_W'($urandom);
        it.tok    = tokenize_sample(raw);
        pending_q = {pending_q, it};
        gen_count++;
        sample_count++;
    endfunction

    // Mostly small values so the gradient lands inside the table range.
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            1, 2:    v = 16'($urandom);
            default: v = 16'($urandom_range(0, 1200) - 600);
        endcase
        return v;
    endfunction

    // One APB transaction: setup cycle, then access until pready.
    task automatic apb_access(input bit wr, input t_reg_idx idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want) begin
            report_mismatch($sformatf("register %s reads %h, expected %h", idx.name(), rd, want));
        end
    endtask

    // Write a register, read it back, and mirror it in the predictor.
    task automatic set_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] unused;
        case (idx)
            REG_MODE:      mask = 32'((1 << MODE_W) - 1);
            REG_ROW_WIDTH: mask = 32'((1 << RWIDTH_W) - 1);
            default:       mask = 32'((1 << CTX_W) - 1);
        endcase
        apb_access(1'b1, idx, value, unused);
        check_reg(idx, value & mask);
        case (idx)
            REG_MODE:      cfg_mode = value[MODE_W-1:0];
            REG_FIXED_CTX: cfg_ctx  = value[CTX_W-1:0];
            REG_ROW_WIDTH: begin
                cfg_width = value[RWIDTH_W-1:0];
                restart_channel();
            end
            default: begin
                cfg_rows = value[RCOUNT_W-1:0];
                restart_channel();
            end
        endcase
        cfg_writes++;
    endtask

    // Idle means every queued transaction taken and every token back, plus a
    // pause that covers table writes still in the pipeline.
    task automatic wait_drained();
        do @(negedge i_clk); while (acc_count != gen_count || token_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Driver: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                cur_item = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_DATA_W - 42){1'b0}}, cur_item.tctx, cur_item.tidx,
                                  cur_item.sample};
                s_axis_tuser  <= cur_item.cmd;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: a random 16-bit ready pattern, redrawn when the step counter wraps.
    logic [15:0] rx_pattern = 16'hFFFF;
    logic [5:0]  rx_step    = '0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_step == 0) begin
                case ($urandom_range(0, 3))
                    0:       rx_pattern = 16'hFFFF;
                    1:       rx_pattern = 16'($urandom & $urandom) | 16'h0001;
                    default: rx_pattern = 16'($urandom) | 16'h0001;
                endcase
            end
            m_axis_tready <= rx_pattern[rx_step[3:0]];
            rx_step = rx_step + 6'd1;
        end
    end

    // Monitor: checks tokens, arms expectations of accepted samples, and
    // watches for a stalled run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (token_q.size() == 0) begin
                    report_mismatch($sformatf("token %h with none expected", m_axis_tdata));
                end else begin
                    want_tok = token_q.pop_front();
                    if (m_axis_tdata[CTX_W-1:0] !== want_tok.ctx) begin
                        report_mismatch($sformatf("token %0d: context_id %h, expected %h",
                            tokens_checked, m_axis_tdata[CTX_W-1:0], want_tok.ctx));
                    end
                    if (m_axis_tdata[CTX_W+RES_W-1:CTX_W] !== want_tok.res) begin
                        report_mismatch($sformatf("token %0d: packed_residual %h, expected %h",
                            tokens_checked, m_axis_tdata[CTX_W+RES_W-1:CTX_W], want_tok.res));
                    end
                    if (m_axis_tlast !== want_tok.chan_end) begin
                        report_mismatch($sformatf("token %0d: last_in_channel %b, expected %b",
                            tokens_checked, m_axis_tlast, want_tok.chan_end));
                    end
                    if (want_tok.chan_end) chan_ends++;
                    tokens_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                acc_count++;
                if (cur_item.cmd == CMD_SAMPLE) token_q = {token_q, cur_item.tok};
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                    $display("** gradient_residual_tokenizer: FAILED **");
                    $finish;
                end
            end
        end
    end

    // Stimulus: reset, directed channels, then random register settings with
    // random sample streams.
    initial begin
        int unsigned pick;
        int unsigned n;
        int unsigned chan;
        int unsigned rand_samples;
        logic [31:0] geo;

        rand_samples = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        check_reg(REG_MODE, 32'(RST_MODE));
        check_reg(REG_FIXED_CTX, 32'(RST_FIXED_CTX));
        check_reg(REG_ROW_WIDTH, 32'(RST_ROW_WIDTH));
        check_reg(REG_ROW_COUNT, 32'(RST_ROW_COUNT));

        // Reset defaults: the largest residuals on the first row.
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);

        // One-sample rows: below the first row each prediction is the sample above.
        wait_drained();
        set_reg(REG_FIXED_CTX, 32'hFFFF);
        set_reg(REG_ROW_WIDTH, 32'd1);
        set_reg(REG_ROW_COUNT, 32'd4);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0000);

        // Zero predictor: the sample itself is packed.
        wait_drained();
        set_reg(REG_MODE, 32'(MODE_ZERO));
        set_reg(REG_FIXED_CTX, 32'h1234);
        set_reg(REG_ROW_WIDTH, 32'd3);
        set_reg(REG_ROW_COUNT, 32'd2);
        queue_sample(16'h8000);
        queue_sample(16'h7FFF);
        queue_sample(16'h0000);
        queue_sample(16'hFFFF);
        queue_sample(16'h0001);
        queue_sample(16'h0064);

        // Table context: both ends of the saturated gradient.
        wait_drained();
        set_reg(REG_MODE, 32'(MODE_TABLE));
        set_reg(REG_ROW_WIDTH, 32'd4);
        queue_table(TIDX_W'(0), 16'hFFFF);
        queue_table(TIDX_W'(TAB_DEPTH - 1), 16'h0000);
        queue_sample(16'(1000));
        queue_sample(16'(-1000));
        queue_sample(16'h0000);
        queue_sample(16'h0005);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0003);
        queue_sample(16'(-3));

        // Unused mode code, zero width and zero row count.
        wait_drained();
        set_reg(REG_MODE, 32'd3);
        set_reg(REG_ROW_WIDTH, 32'd0);
        set_reg(REG_ROW_COUNT, 32'd0);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(16'h7FFF);

        // Width above the line buffer: the row is cut to the line buffer length.
        wait_drained();
        set_reg(REG_MODE, 32'(MODE_TABLE));
        set_reg(REG_ROW_WIDTH, 32'd2047);
        for (int k = 0; k < 30; k++) queue_sample(pick_sample());

        // Widest legal row with the most rows.
        wait_drained();
        set_reg(REG_MODE, 32'(MODE_GRAD));
        set_reg(REG_FIXED_CTX, 32'h0000);
        set_reg(REG_ROW_WIDTH, 32'd1024);
        set_reg(REG_ROW_COUNT, 32'd65535);
        for (int k = 0; k < 40; k++) queue_sample(pick_sample());

        // Random settings, with junk in the unused register bits.
        while (rand_samples < RANDOM_SAMPLES) begin
            wait_drained();
            pick = $urandom_range(0, 6);
            set_reg(REG_MODE, ($urandom & ~32'h3) | ((pick == 6) ? 32'd3 : 32'(pick % 3)));
            case ($urandom_range(0, 3))
                0:       set_reg(REG_FIXED_CTX, $urandom & ~32'hFFFF);
                1:       set_reg(REG_FIXED_CTX, $urandom | 32'hFFFF);
                default: set_reg(REG_FIXED_CTX, $urandom);
            endcase
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       geo = 32'd0;
                    1:       geo = 32'd1;
                    2:       geo = $urandom_range(1024, 2047);
                    default: geo = $urandom_range(2, 12);
                endcase
                set_reg(REG_ROW_WIDTH, ($urandom & ~32'h7FF) | geo);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       geo = 32'd0;
                    1:       geo = 32'd65535;
                    default: geo = $urandom_range(1, 5);
                endcase
                set_reg(REG_ROW_COUNT, ($urandom & ~32'hFFFF) | geo);
            end
            chan = row_len() * row_total();
            n = (chan <= 80) ? chan * $urandom_range(1, 2) + $urandom_range(0, 3)
                             : $urandom_range(10, 40);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 7) == 0) queue_table(TIDX_W'($urandom), CTX_W'($urandom));
                queue_sample(pick_sample());
            end
            rand_samples += n;
        end

        wait_drained();
        $display("Sent %0d samples and %0d table writes over %0d register writes, all four modes.",
                 sample_count, table_count, cfg_writes);
        $display("Checked %0d tokens, %0d of them closing a channel; %0d mismatches.",
                 tokens_checked, chan_ends, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** gradient_residual_tokenizer: PASSED **");
        end else begin
            $display("** gradient_residual_tokenizer: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/grt_pkg.sv
design/gradient_residual_tokenizer.sv
verif/tb_top.sv
